[rtl/core/mbc_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Magma block cipher package
// Shared constants, command struct and the round function.
// -----------------------------------------------------------------------------
package mbc_pkg;

  localparam int unsigned BlockW   = 64;
  localparam int unsigned HalfW    = 32;
  localparam int unsigned KeyWords = 8;
  localparam int unsigned KeyIdxW  = 3;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned RoundW   = 5;
  localparam int unsigned RotLeft  = 11;

  localparam logic [RoundW-1:0] LastRound = 5'd31;

  localparam logic ActEncrypt = 1'b0;
  localparam logic ActDecrypt = 1'b1;

  typedef struct packed {
    logic              load;
    logic              step;
    logic              last;
    logic [RoundW-1:0] rnd;
  } mbc_cmd_t;

  // Nibble j of entry i is S-box j applied to i.
  localparam logic [HalfW-1:0] SboxPacked [16] = '{
    32'h1857cb6c, 32'h7edf8384, 32'he2f52526, 32'hd56a1832,
    32'h0698d29a, 32'h59214fa5, 32'h81c6fa5b, 32'h3cad6dc9,
    32'h4fb07e1e, 32'hf47901e8, 32'hab83a74d, 32'h601e5477,
    32'h9d4b3cb0, 32'hca34e9d3, 32'hb3e2960f, 32'h270cb0f1
  };

  function automatic logic [HalfW-1:0] subst(input logic [HalfW-1:0] x);
    logic [HalfW-1:0] r;
    logic [HalfW-1:0] e;
    r = '0;
    for (int j = 0; j < 8; j++) begin
      e = SboxPacked[x[4*j +: 4]];
      r[4*j +: 4] = e[4*j +: 4];
    end
    return r;
  endfunction

  function automatic logic [HalfW-1:0] round_fn(input logic [HalfW-1:0] half,
                                                input logic [HalfW-1:0] k);
    logic [HalfW-1:0] s;
    s = subst(half + k);
    return {s[HalfW-RotLeft-1:0], s[HalfW-1:HalfW-RotLeft]};
  endfunction

endpackage

[rtl/core/magma_block_cipher.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Magma block cipher
// 64-bit block, 256-bit key, 32 Feistel rounds, encrypt or decrypt.
// -----------------------------------------------------------------------------
// channel  | handshake               | payload
// request  | start_i, busy_o         | action_i, block_in_i
// result   | done_o (one-cycle)      | block_out_o
// config   | cfg_valid_i, cfg_ready_o| cfg_index_i, cfg_data_i
//
// One round per cycle through a single round unit: busy_o is high while the
// rounds of an accepted request run, done_o pulses on the cycle after the last round.
// busy_o drops on the done_o cycle, so a new request may start then;
// no new request is taken while busy_o is high.
// Reset clears the key to zero; config is always ready.
// -----------------------------------------------------------------------------
module magma_block_cipher import mbc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               action_i,
  input  logic [BlockW-1:0]  block_in_i,
  output logic               done_o,
  output logic [BlockW-1:0]  block_out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [HalfW-1:0]   cfg_data_i
);

  mbc_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  mbc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  mbc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .action_i    (action_i),
    .block_in_i  (block_in_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .block_out_o (block_out_o)
  );

endmodule

[rtl/core/mbc_ctrl.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Magma round controller
// Sequences 32 rounds per request and strobes the result.
// -----------------------------------------------------------------------------
module mbc_ctrl import mbc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  output logic     done_o,
  output mbc_cmd_t cmd_o
);

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  state_e            state_q;
  logic [RoundW-1:0] cnt_q;
  logic              done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            state_q <= StRun;
            cnt_q   <= '0;
          end
        end
        StRun: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LastRound) begin
            state_q <= StIdle;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o     = (state_q != StIdle);
  assign done_o     = done_q;
  assign cmd_o.load = (state_q == StIdle) && start_i;
  assign cmd_o.step = (state_q == StRun);
  assign cmd_o.last = (state_q == StRun) && (cnt_q == LastRound);
  assign cmd_o.rnd  = cnt_q;

endmodule

[rtl/core/mbc_datapath.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Magma datapath
// Key registers, round key select, one Feistel round and result register.
// -----------------------------------------------------------------------------
module mbc_datapath import mbc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mbc_cmd_t           cmd_i,
  input  logic               action_i,
  input  logic [BlockW-1:0]  block_in_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [HalfW-1:0]   cfg_data_i,
  output logic [BlockW-1:0]  block_out_o
);

  logic [HalfW-1:0]   key_q [KeyWords];
  logic [HalfW-1:0]   a1_q, a0_q;
  logic               dec_q;
  logic [BlockW-1:0]  out_q;
  logic [RoundW-1:0]  idx;
  logic [KeyIdxW-1:0] kidx;
  logic [HalfW-1:0]   f;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KeyWords; i++) key_q[i] <= '0;
    end else if (cfg_we_i && !cfg_index_i[CfgIdxW-1]) begin
      key_q[cfg_index_i[KeyIdxW-1:0]] <= cfg_data_i;
    end
  end

  always_comb begin
    idx  = (dec_q == ActDecrypt) ? ~cmd_i.rnd : cmd_i.rnd;
    kidx = (idx[RoundW-1:KeyIdxW] == 2'b11) ? ~idx[KeyIdxW-1:0] : idx[KeyIdxW-1:0];
    f    = round_fn(a0_q, key_q[kidx]) ^ a1_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dec_q <= action_i;
      a1_q  <= block_in_i[BlockW-1:HalfW];
      a0_q  <= block_in_i[HalfW-1:0];
    end else if (cmd_i.step) begin
      a1_q <= a0_q;
      a0_q <= f;
    end
    if (cmd_i.last) begin
      out_q <= {f, a0_q};
    end
  end

  assign block_out_o = out_q;

endmodule
